// File: hdl/mecanum_inverse_kinematics_degraded_assert.svh
// assertion macros shared by the rtl
`ifndef MECANUM_INVERSE_KINEMATICS_DEGRADED_ASSERT_SVH
`define MECANUM_INVERSE_KINEMATICS_DEGRADED_ASSERT_SVH

`ifndef SYNTHESIS
`define MIK_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");
`define MIK_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define MIK_ASSERT_NOW(label, ante, cons)
`define MIK_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// File: hdl/mik_pkg.sv
package mik_pkg;

    localparam int VEL_W   = 16;
    localparam int SPEED_W = 16;
    localparam int CFG_W   = 16;
    localparam int ROT_W   = 32;
    localparam int SUM_W   = 34;
    localparam int PROD_W  = 50;
    localparam int FRAC_SH = 24;

    localparam logic [2:0] MODE_NONE = 3'd0;
    localparam logic [2:0] MODE_LF   = 3'd1;
    localparam logic [2:0] MODE_LB   = 3'd2;
    localparam logic [2:0] MODE_RF   = 3'd3;
    localparam logic [2:0] MODE_RB   = 3'd4;

    localparam logic [1:0] WHEEL_LF = 2'd0;
    localparam logic [1:0] WHEEL_LB = 2'd1;
    localparam logic [1:0] WHEEL_RF = 2'd2;
    localparam logic [1:0] WHEEL_RB = 2'd3;

    localparam logic CFG_ARM_LENGTH_SUM = 1'b0;
    localparam logic CFG_INVERSE_RADIUS = 1'b1;

    localparam logic [CFG_W-1:0] ARM_LENGTH_SUM_RST = 16'd26214;
    localparam logic [CFG_W-1:0] INVERSE_RADIUS_RST = 16'd3369;

    typedef struct packed {
        logic x_en;
        logic x_neg;
        logic y_en;
        logic y_neg;
        logic r_en;
    } t_mix;

    localparam t_mix MIX_ZERO = '{x_en: 1'b0, x_neg: 1'b0, y_en: 1'b0, y_neg: 1'b0, r_en: 1'b0};
    localparam t_mix MIX_PX   = '{x_en: 1'b1, x_neg: 1'b0, y_en: 1'b0, y_neg: 1'b0, r_en: 1'b0};
    localparam t_mix MIX_NX   = '{x_en: 1'b1, x_neg: 1'b1, y_en: 1'b0, y_neg: 1'b0, r_en: 1'b0};
    localparam t_mix MIX_PY   = '{x_en: 1'b0, x_neg: 1'b0, y_en: 1'b1, y_neg: 1'b0, r_en: 1'b0};
    localparam t_mix MIX_NY   = '{x_en: 1'b0, x_neg: 1'b0, y_en: 1'b1, y_neg: 1'b1, r_en: 1'b0};
    localparam t_mix MIX_R    = '{x_en: 1'b0, x_neg: 1'b0, y_en: 1'b0, y_neg: 1'b0, r_en: 1'b1};

    typedef struct packed {
        logic s2;
        logic s3;
        logic s4;
    } t_stage_en;

endpackage

// File: hdl/mik_lane.sv
module mik_lane (
    input  logic                                i_clk,
    input  mik_pkg::t_stage_en                  i_en,
    input  mik_pkg::t_mix                       i_mix,
    input  logic signed [mik_pkg::VEL_W-1:0]    i_vel_x,
    input  logic signed [mik_pkg::VEL_W-1:0]    i_vel_y,
    input  logic signed [mik_pkg::ROT_W-1:0]    i_rot,
    input  logic        [mik_pkg::CFG_W-1:0]    i_inverse_radius,
    output logic signed [mik_pkg::SPEED_W-1:0]  o_speed
);
    import mik_pkg::*;

    logic signed [SUM_W-1:0]      w_x;
    logic signed [SUM_W-1:0]      w_y;
    logic signed [SUM_W-1:0]      w_r;
    logic signed [SUM_W-1:0]      w_tx;
    logic signed [SUM_W-1:0]      w_ty;
    logic signed [SUM_W-1:0]      w_tr;
    logic signed [SUM_W-1:0]      n_sum;
    logic signed [SUM_W-1:0]      r_sum;
    logic signed [PROD_W:0]       w_prod;
    logic signed [PROD_W-1:0]     r_prod;
    logic signed [PROD_W-1:0]     w_rnd;
    logic signed [PROD_W-FRAC_SH-1:0] w_q;
    logic signed [SPEED_W-1:0]    n_speed;
    logic signed [SPEED_W-1:0]    r_speed;

    // stage 2: signed mix of the translation and rotation terms
    always_comb begin
        w_x  = {{(SUM_W-VEL_W-16){i_vel_x[VEL_W-1]}}, i_vel_x, 16'b0};
        w_y  = {{(SUM_W-VEL_W-16){i_vel_y[VEL_W-1]}}, i_vel_y, 16'b0};
        w_r  = {{(SUM_W-ROT_W){i_rot[ROT_W-1]}}, i_rot};
        w_tx = i_mix.x_en ? (i_mix.x_neg ? -w_x : w_x) : '0;
        w_ty = i_mix.y_en ? (i_mix.y_neg ? -w_y : w_y) : '0;
        w_tr = i_mix.r_en ? w_r : '0;
        n_sum = w_tx + w_ty + w_tr;
    end

    // stage 3: scale by inverse radius
    assign w_prod = r_sum * $signed({1'b0, i_inverse_radius});

    // stage 4: round half up and saturate
    always_comb begin
        w_rnd = r_prod + $signed({{(PROD_W-FRAC_SH){1'b0}}, 1'b1, {(FRAC_SH-1){1'b0}}});
        w_q   = w_rnd[PROD_W-1:FRAC_SH];
        if (w_q[PROD_W-FRAC_SH-1:SPEED_W-1] == '0 ||
            w_q[PROD_W-FRAC_SH-1:SPEED_W-1] == '1) begin
            n_speed = w_q[SPEED_W-1:0];
        end else if (w_q[PROD_W-FRAC_SH-1]) begin
            n_speed = {1'b1, {(SPEED_W-1){1'b0}}};
        end else begin
            n_speed = {1'b0, {(SPEED_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_sum <= n_sum;
        end
        if (i_en.s3) begin
            r_prod <= w_prod[PROD_W-1:0];
        end
        if (i_en.s4) begin
            r_speed <= n_speed;
        end
    end

    assign o_speed = r_speed;

endmodule

// File: hdl/mecanum_inverse_kinematics_degraded.sv
// mecanum wheel inverse kinematics with one-wheel-offline fallback
// input stream: one beat per chassis command (mode, vel_x, vel_y, yaw_rate)
// output stream: one beat per command, four Q8.8 wheel speeds and a 4-bit
// mask of driven wheels; undriven wheels read zero, modes 5 to 7 drive none
// config channel: index 0 arm_length_sum, index 1 inverse_radius, always
// ready; write only while no command is in flight
// pipeline: four register stages (decode and yaw product, wheel sum,
// radius product, round and saturate); o_m_tvalid is the fourth stage's
// valid bit, and one beat per cycle is sustained while i_m_tready is high
// stall: when i_m_tready is low the output register holds its beat and
// empty stages behind it keep filling; o_s_tready falls only when every
// stage holds a beat, so nothing is dropped or repeated
// reset: pipeline emptied, config registers back to their defaults
`include "mecanum_inverse_kinematics_degraded_assert.svh"

module mecanum_inverse_kinematics_degraded (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [55:0] i_s_tdata,   // mode[2:0], vel_x, vel_y, yaw_rate, zero pad
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [71:0] o_m_tdata,   // speed lf, lb, rf, rb, wheel_valid[3:0], zero pad
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [mik_pkg::CFG_W-1:0] i_cfg_data
);
    import mik_pkg::*;

    logic [CFG_W-1:0] r_arm_length_sum;
    logic [CFG_W-1:0] r_inverse_radius;

    logic        w_rdy1;
    logic        w_rdy2;
    logic        w_rdy3;
    logic        w_rdy4;
    logic        r_v1;
    logic        r_v2;
    logic        r_v3;
    logic        r_v4;

    logic [2:0]              w_mode;
    logic signed [VEL_W-1:0] w_vx;
    logic signed [VEL_W-1:0] w_vy;
    logic signed [VEL_W-1:0] w_yaw;
    logic [VEL_W:0]          w_abs_x;
    logic [VEL_W:0]          w_abs_y;
    logic                    w_moving;
    logic                    w_xdom;
    logic signed [ROT_W:0]   w_rot_full;

    t_mix [3:0]  n_mix;
    logic [3:0]  n_wv;

    t_mix [3:0]              r_mix;
    logic signed [VEL_W-1:0] r_vx;
    logic signed [VEL_W-1:0] r_vy;
    logic signed [ROT_W-1:0] r_rot;
    logic [3:0]              r_wv1;
    logic [3:0]              r_wv2;
    logic [3:0]              r_wv3;
    logic [3:0]              r_wv4;

    t_stage_en            w_en;
    logic [3:0][SPEED_W-1:0] w_speed;
    logic [3:0]              w_undriven_ok;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arm_length_sum <= ARM_LENGTH_SUM_RST;
            r_inverse_radius <= INVERSE_RADIUS_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ARM_LENGTH_SUM: r_arm_length_sum <= i_cfg_data;
                CFG_INVERSE_RADIUS: r_inverse_radius <= i_cfg_data;
            endcase
        end
    end

    assign w_rdy4 = !r_v4 || i_m_tready;
    assign w_rdy3 = !r_v3 || w_rdy4;
    assign w_rdy2 = !r_v2 || w_rdy3;
    assign w_rdy1 = !r_v1 || w_rdy2;
    assign o_s_tready = w_rdy1;

    assign w_en = '{s2: w_rdy2, s3: w_rdy3, s4: w_rdy4};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_rdy1) begin
                r_v1 <= i_s_tvalid;
            end
            if (w_rdy2) begin
                r_v2 <= r_v1;
            end
            if (w_rdy3) begin
                r_v3 <= r_v2;
            end
            if (w_rdy4) begin
                r_v4 <= r_v3;
            end
        end
    end

    assign w_mode = i_s_tdata[2:0];
    assign w_vx   = i_s_tdata[18:3];
    assign w_vy   = i_s_tdata[34:19];
    assign w_yaw  = i_s_tdata[50:35];

    assign w_rot_full = w_yaw * $signed({1'b0, r_arm_length_sum});

    // stage 1: pick the driven wheels and their terms
    always_comb begin
        w_abs_x  = w_vx[VEL_W-1] ? -{w_vx[VEL_W-1], w_vx} : {w_vx[VEL_W-1], w_vx};
        w_abs_y  = w_vy[VEL_W-1] ? -{w_vy[VEL_W-1], w_vy} : {w_vy[VEL_W-1], w_vy};
        w_moving = (w_vx != '0) || (w_vy != '0);
        w_xdom   = w_abs_x >= w_abs_y;
        n_mix    = {4{MIX_ZERO}};
        n_wv     = '0;
        unique case (w_mode)
            MODE_NONE: begin
                n_mix[WHEEL_RF] = t_mix'(MIX_NX | MIX_NY | MIX_R);
                n_mix[WHEEL_LF] = t_mix'(MIX_PX | MIX_NY | MIX_R);
                n_mix[WHEEL_LB] = t_mix'(MIX_PX | MIX_PY | MIX_R);
                n_mix[WHEEL_RB] = t_mix'(MIX_NX | MIX_PY | MIX_R);
                n_wv = 4'hF;
            end
            MODE_LF, MODE_RF: begin
                priority if (w_moving && w_xdom) begin
                    n_mix[WHEEL_LB] = MIX_PX;
                    n_mix[WHEEL_RB] = MIX_NX;
                end else if (w_moving && w_mode == MODE_LF) begin
                    n_mix[WHEEL_RF] = MIX_NY;
                    n_mix[WHEEL_RB] = MIX_PY;
                end else if (w_moving) begin
                    n_mix[WHEEL_LF] = MIX_NY;
                    n_mix[WHEEL_LB] = MIX_PY;
                end else if (w_mode == MODE_LF) begin
                    n_mix[WHEEL_RF] = MIX_R;
                    n_mix[WHEEL_LB] = MIX_R;
                end else begin
                    n_mix[WHEEL_LF] = MIX_R;
                    n_mix[WHEEL_RB] = MIX_R;
                end
                for (int k = 0; k < 4; k++) begin
                    n_wv[k] = (n_mix[k] != MIX_ZERO);
                end
            end
            MODE_LB, MODE_RB: begin
                priority if (w_moving && w_xdom) begin
                    n_mix[WHEEL_RF] = MIX_NX;
                    n_mix[WHEEL_LF] = MIX_PX;
                end else if (w_moving && w_mode == MODE_LB) begin
                    n_mix[WHEEL_RF] = MIX_NY;
                    n_mix[WHEEL_RB] = MIX_PY;
                end else if (w_moving) begin
                    n_mix[WHEEL_LF] = MIX_NY;
                    n_mix[WHEEL_LB] = MIX_PY;
                end else if (w_mode == MODE_LB) begin
                    n_mix[WHEEL_RF] = MIX_R;
                    n_mix[WHEEL_LF] = MIX_R;
                end else begin
                    n_mix[WHEEL_RF] = MIX_R;
                    n_mix[WHEEL_LB] = MIX_R;
                end
                for (int k = 0; k < 4; k++) begin
                    n_wv[k] = (n_mix[k] != MIX_ZERO);
                end
            end
            default: begin
                n_wv = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1) begin
            r_mix <= n_mix;
            r_vx  <= w_vx;
            r_vy  <= w_vy;
            r_rot <= w_rot_full[ROT_W-1:0];
            r_wv1 <= n_wv;
        end
        if (w_rdy2) begin
            r_wv2 <= r_wv1;
        end
        if (w_rdy3) begin
            r_wv3 <= r_wv2;
        end
        if (w_rdy4) begin
            r_wv4 <= r_wv3;
        end
    end

    for (genvar g = 0; g < 4; g++) begin : g_lane
        mik_lane u_lane (
            .i_clk            (i_clk),
            .i_en             (w_en),
            .i_mix            (r_mix[g]),
            .i_vel_x          (r_vx),
            .i_vel_y          (r_vy),
            .i_rot            (r_rot),
            .i_inverse_radius (r_inverse_radius),
            .o_speed          (w_speed[g])
        );
    end

    assign o_m_tvalid = r_v4;
    assign o_m_tdata  = {4'b0, r_wv4, w_speed[WHEEL_RB], w_speed[WHEEL_RF],
                         w_speed[WHEEL_LB], w_speed[WHEEL_LF]};

    // a wheel that is not driven reads zero
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_undriven_ok[k] = r_wv4[k] || (w_speed[k] == '0);
        end
    end

    `MIK_ASSERT_NOW(a_undriven_zero, o_m_tvalid, &w_undriven_ok)
    `MIK_ASSERT_NOW(a_mask_shape, o_m_tvalid, $countones(r_wv4) == 0 || $countones(r_wv4) == 2 || r_wv4 == 4'hF)
    `MIK_ASSERT_NOW(a_flow_no_backpressure, i_m_tready, o_s_tready)
    `MIK_ASSERT_NEXT(a_last_stage_moves, r_v3 && w_rdy4, o_m_tvalid)

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import mik_pkg::*;

    class wheel_speed_board;
        logic [CFG_W-1:0] arm_len;
        logic [CFG_W-1:0] inv_radius;
        logic [67:0]      speed_q[$];
        int               mismatches;
        int               commands;
        int               offline_cmds;
        int               unknown_cmds;
        int               results;

        function new();
            arm_len      = ARM_LENGTH_SUM_RST;
            inv_radius   = INVERSE_RADIUS_RST;
            mismatches   = 0;
            commands     = 0;
            offline_cmds = 0;
            unknown_cmds = 0;
            results      = 0;
        endfunction

        function void write_reg(logic index, logic [CFG_W-1:0] value);
            if (index == CFG_ARM_LENGTH_SUM)
                arm_len = value;
            else
                inv_radius = value;
        endfunction

        function logic [SPEED_W-1:0] wheel_rate(longint sum24);
            longint inv;
            longint q;
            inv = inv_radius;
            q = (sum24 * inv + (longint'(1) <<< 23)) >>> FRAC_SH;
            if (q > 32767)
                q = 32767;
            if (q < -32768)
                q = -32768;
            return q[SPEED_W-1:0];
        endfunction

        function void note_command(logic [55:0] beat);
            logic [2:0]  mode;
            longint      vx, vy, az, arm, x, y, r;
            longint      s[4];
            logic [3:0]  drive;
            logic [67:0] exp_speeds;
            bit          moving, xdom;
            mode = beat[2:0];
            vx   = $signed(beat[18:3]);
            vy   = $signed(beat[34:19]);
            az   = $signed(beat[50:35]);
            arm  = arm_len;
            x    = vx * 65536;
            y    = vy * 65536;
            r    = az * arm;
            foreach (s[i])
                s[i] = 0;
            drive  = 4'd0;
            moving = (vx != 0) || (vy != 0);
            xdom   = ((vx < 0) ? -vx : vx) >= ((vy < 0) ? -vy : vy);
            commands++;
            case (mode)
                MODE_NONE: begin
                    s[WHEEL_RF] = -x - y + r;
                    s[WHEEL_LF] =  x - y + r;
                    s[WHEEL_LB] =  x + y + r;
                    s[WHEEL_RB] = -x + y + r;
                    drive = 4'hf;
                end
                MODE_LF, MODE_RF: begin
                    offline_cmds++;
                    if (moving && xdom) begin
                        s[WHEEL_LB] = x;
                        s[WHEEL_RB] = -x;
                        drive[WHEEL_LB] = 1'b1;
                        drive[WHEEL_RB] = 1'b1;
                    end else if (moving && mode == MODE_LF) begin
                        s[WHEEL_RF] = -y;
                        s[WHEEL_RB] = y;
                        drive[WHEEL_RF] = 1'b1;
                        drive[WHEEL_RB] = 1'b1;
                    end else if (moving) begin
                        s[WHEEL_LF] = -y;
                        s[WHEEL_LB] = y;
                        drive[WHEEL_LF] = 1'b1;
                        drive[WHEEL_LB] = 1'b1;
                    end else if (mode == MODE_LF) begin
                        s[WHEEL_RF] = r;
                        s[WHEEL_LB] = r;
                        drive[WHEEL_RF] = 1'b1;
                        drive[WHEEL_LB] = 1'b1;
                    end else begin
                        s[WHEEL_LF] = r;
                        s[WHEEL_RB] = r;
                        drive[WHEEL_LF] = 1'b1;
                        drive[WHEEL_RB] = 1'b1;
                    end
                end
                MODE_LB, MODE_RB: begin
                    offline_cmds++;
                    if (moving && xdom) begin
                        s[WHEEL_RF] = -x;
                        s[WHEEL_LF] = x;
                        drive[WHEEL_RF] = 1'b1;
                        drive[WHEEL_LF] = 1'b1;
                    end else if (moving && mode == MODE_LB) begin
                        s[WHEEL_RF] = -y;
                        s[WHEEL_RB] = y;
                        drive[WHEEL_RF] = 1'b1;
                        drive[WHEEL_RB] = 1'b1;
                    end else if (moving) begin
                        s[WHEEL_LF] = -y;
                        s[WHEEL_LB] = y;
                        drive[WHEEL_LF] = 1'b1;
                        drive[WHEEL_LB] = 1'b1;
                    end else if (mode == MODE_LB) begin
                        s[WHEEL_RF] = r;
                        s[WHEEL_LF] = r;
                        drive[WHEEL_RF] = 1'b1;
                        drive[WHEEL_LF] = 1'b1;
                    end else begin
                        s[WHEEL_RF] = r;
                        s[WHEEL_LB] = r;
                        drive[WHEEL_RF] = 1'b1;
                        drive[WHEEL_LB] = 1'b1;
                    end
                end
                default: begin
                    unknown_cmds++;
                end
            endcase
            exp_speeds = '0;
            for (int w = 0; w < 4; w++)
                if (drive[w])
                    exp_speeds[16*w +: 16] = wheel_rate(s[w]);
            exp_speeds[67:64] = drive;
            speed_q.push_back(exp_speeds);
        endfunction

        task report(string what, logic [15:0] got, logic [15:0] want);
            mismatches++;
            if (mismatches <= 40)
                $display("mismatch at %0t: %s got %h expected %h", $time, what, got, want);
        endtask

        task check_result(logic [71:0] beat);
            logic [67:0] want;
            string       wheel_name[4];
            wheel_name = '{"speed lf", "speed lb", "speed rf", "speed rb"};
            if (speed_q.size() == 0) begin
                report("unexpected output beat", beat[15:0], 16'd0);
            end else begin
                want = speed_q.pop_front();
                results++;
                for (int w = 0; w < 4; w++)
                    if (beat[16*w +: 16] !== want[16*w +: 16])
                        report(wheel_name[w], beat[16*w +: 16], want[16*w +: 16]);
                if (beat[67:64] !== want[67:64])
                    report("wheel_valid", 16'(beat[67:64]), 16'(want[67:64]));
            end
        endtask
    endclass

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_PERIODIC, RX_CHOKED} rx_style_e;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_s_tvalid  = 1'b0;
    logic [55:0] i_s_tdata   = '0;
    logic        i_m_tready  = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        i_cfg_index = CFG_ARM_LENGTH_SUM;
    logic [CFG_W-1:0] i_cfg_data = '0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [71:0] o_m_tdata;
    logic        o_cfg_ready;

    rx_style_e   rx_style = RX_OPEN;
    logic [7:0]  rx_phase = '0;
    int          burst_left = 0;
    int          gain_sets = 1;

    wheel_speed_board speeds = new();

    mecanum_inverse_kinematics_degraded u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // output backpressure, style switches whenever the low six bits of rx_phase are zero
    always @(posedge i_clk) begin
        rx_phase <= rx_phase + 8'd1;
        if (rx_phase[5:0] == 6'd0)
            rx_style <= rx_style_e'($urandom_range(0, 3));
        case (rx_style)
            RX_OPEN:     i_m_tready <= 1'b1;
            RX_COIN:     i_m_tready <= 1'($urandom_range(0, 1));
            RX_PERIODIC: i_m_tready <= (rx_phase[2:0] < 3'd3);
            default:     i_m_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready)
                speeds.check_result(o_m_tdata);
            if (i_s_tvalid && o_s_tready)
                speeds.note_command(i_s_tdata);
            if (i_cfg_valid && o_cfg_ready)
                speeds.write_reg(i_cfg_index, i_cfg_data);
        end
    end

    function automatic logic [55:0] pack_command(logic [2:0] mode, logic [15:0] vx,
                                                 logic [15:0] vy, logic [15:0] az);
        return {5'd0, az, vy, vx, mode};
    endfunction

    function automatic logic [15:0] random_velocity();
        logic [15:0] v;
        v = 16'($urandom);
        if ($urandom_range(0, 1))
            v = 16'($urandom_range(0, 1023)) - 16'd512;
        return v;
    endfunction

    function automatic logic [55:0] random_command();
        logic [2:0]  mode;
        logic [15:0] vx, vy, az;
        if ($urandom_range(0, 15) == 0)
            mode = MODE_RB + 3'($urandom_range(1, 3));
        else
            mode = 3'($urandom_range(MODE_NONE, MODE_RB));
        vx = random_velocity();
        vy = random_velocity();
        az = random_velocity();
        case ($urandom_range(0, 9))
            0: begin
                vx = '0;
                vy = '0;
            end
            1: vy = $urandom_range(0, 1) ? vx : -vx;
            2: vx = '0;
            3: vy = '0;
            default: ;
        endcase
        return pack_command(mode, vx, vy, az);
    endfunction

    task send_command(logic [55:0] beat);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= beat;
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        if (burst_left == 0) begin
            burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60)
                                                    : $urandom_range(1, 12);
            if ($urandom_range(0, 2) != 0) begin
                i_s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6))
                    @(posedge i_clk);
            end
        end else begin
            burst_left--;
        end
    endtask

    task drain();
        i_s_tvalid <= 1'b0;
        while (speeds.speed_q.size() != 0)
            @(posedge i_clk);
        repeat (6)
            @(posedge i_clk);
    endtask

    // leaves valid high so that writes can follow back to back
    task write_reg(logic index, logic [CFG_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
    endtask

    task run_directed();
        send_command(pack_command(MODE_NONE, 16'd300, -16'sd100, 16'd50));
        send_command(pack_command(MODE_NONE, 16'h7fff, 16'h7fff, 16'h7fff));
        send_command(pack_command(MODE_NONE, 16'h8000, 16'h8000, 16'h8000));
        send_command(pack_command(MODE_NONE, 16'd0, 16'd0, 16'd0));
        send_command(pack_command(MODE_LF, 16'h8000, 16'd100, 16'h7fff));
        send_command(pack_command(MODE_LF, 16'd50, -16'sd300, 16'd20));
        send_command(pack_command(MODE_LF, 16'd0, 16'd0, -16'sd90));
        send_command(pack_command(MODE_LB, 16'd600, -16'sd200, 16'd10));
        send_command(pack_command(MODE_LB, -16'sd10, 16'h7fff, 16'h8000));
        send_command(pack_command(MODE_LB, 16'd0, 16'd0, 16'h8000));
        send_command(pack_command(MODE_LB, 16'd0, 16'd0, 16'd0));
        send_command(pack_command(MODE_RF, -16'sd500, 16'd499, 16'd7));
        send_command(pack_command(MODE_RF, 16'd1, 16'h8000, 16'd30));
        send_command(pack_command(MODE_RF, 16'd0, 16'd0, 16'h7fff));
        send_command(pack_command(MODE_RF, 16'd256, -16'sd256, 16'd5));
        send_command(pack_command(MODE_RB, 16'h7fff, 16'd0, -16'sd1));
        send_command(pack_command(MODE_RB, 16'd0, -16'sd1, 16'd100));
        send_command(pack_command(MODE_RB, 16'd0, 16'd0, 16'd1));
        send_command(pack_command(MODE_RB, 16'd0, 16'd0, 16'd0));
        send_command(pack_command(MODE_RB + 3'd1, 16'h7fff, 16'h8000, 16'h7fff));
        send_command(pack_command(MODE_RB + 3'd2, 16'd0, 16'd0, 16'h8000));
        send_command(pack_command(MODE_RB + 3'd3, 16'h8000, 16'h7fff, 16'd0));
    endtask

    initial begin
        logic [CFG_W-1:0] arm_set[7];
        logic [CFG_W-1:0] inv_set[7];
        arm_set = '{16'd0, 16'hffff, ARM_LENGTH_SUM_RST, 16'hffff, 16'd1, 16'h0000, 16'h0000};
        inv_set = '{16'd0, 16'hffff, INVERSE_RADIUS_RST, 16'd256, 16'hffff, 16'h0000, 16'h0000};
        arm_set[5] = 16'($urandom);
        inv_set[5] = 16'($urandom);
        arm_set[6] = 16'($urandom_range(0, 65535));
        inv_set[6] = 16'($urandom_range(128, 1024));
        repeat (12)
            @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_directed();
        foreach (arm_set[p]) begin
            drain();
            write_reg(CFG_ARM_LENGTH_SUM, arm_set[p]);
            write_reg(CFG_INVERSE_RADIUS, inv_set[p]);
            i_cfg_valid <= 1'b0;
            gain_sets++;
            repeat (200)
                send_command(random_command());
        end
        drain();
        repeat (10)
            @(posedge i_clk);
        foreach (speeds.speed_q[k])
            speeds.report("missing output beat", 16'd0, speeds.speed_q[k][15:0]);
        $display("%0d commands checked under %0d gain settings", speeds.results, gain_sets);
        $display("%0d with a wheel offline, %0d with an undefined mode",
                 speeds.offline_cmds, speeds.unknown_cmds);
        if (speeds.mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #400000;
        $display("simulation failed");
        $finish;
    end

endmodule
